[sv/lsmu_pkg.sv]
package lsmu_pkg;

  localparam int NumRegs = 8;

  // 8-bit register codes
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegF = 3'd6;
  localparam logic [2:0] RegA = 3'd7;

  // register pair codes
  localparam logic [2:0] PairBc = 3'd0;
  localparam logic [2:0] PairDe = 3'd1;
  localparam logic [2:0] PairHl = 3'd2;
  localparam logic [2:0] PairSp = 3'd3;
  localparam logic [2:0] PairAf = 3'd4;

  localparam logic [15:0] HiPage    = 16'hFF00;
  localparam logic [15:0] PopAfMask = 16'hFFF0;

  typedef enum logic [4:0] {
    OP_LD_R_R     = 5'd0,
    OP_LD_R_N     = 5'd1,
    OP_LD_R_HL    = 5'd2,
    OP_LD_HL_R    = 5'd3,
    OP_LD_HL_N    = 5'd4,
    OP_LD_RR_A    = 5'd5,
    OP_LD_A_RR    = 5'd6,
    OP_LD_NN_A    = 5'd7,
    OP_LD_A_NN    = 5'd8,
    OP_LDH_A_C    = 5'd9,
    OP_LDH_C_A    = 5'd10,
    OP_LDH_A_N    = 5'd11,
    OP_LDH_N_A    = 5'd12,
    OP_LD_A_HLI   = 5'd13,
    OP_LD_HLI_A   = 5'd14,
    OP_LD_RR_NN   = 5'd15,
    OP_LD_NN_SP   = 5'd16,
    OP_LD_SP_HL   = 5'd17,
    OP_POP        = 5'd18,
    OP_PUSH       = 5'd19,
    OP_LD_HL_SPE  = 5'd20
  } op_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_WR   = 2'd2
  } bus_e;

  typedef logic [NumRegs-1:0][7:0] rf_t;

  typedef struct packed {
    logic       req_type;
    logic [4:0] op_kind;
    logic [2:0] dst_sel;
    logic [2:0] src_sel;
    logic       step_up;
    logic [7:0] read_data;
  } item_t;

  typedef struct packed {
    logic       step_up;
    logic [2:0] src_sel;
    logic [2:0] dst_sel;
    logic [4:0] op_kind;
  } held_t;

  typedef struct packed {
    logic [1:0]  bus_op;
    logic [15:0] bus_addr;
    logic [7:0]  write_byte;
    logic        done_res;
  } res_t;

  function automatic logic [15:0] pair_get(rf_t rf, logic [15:0] sp, logic [2:0] code);
    logic [15:0] v;
    case (code)
      PairBc:  v = {rf[RegB], rf[RegC]};
      PairDe:  v = {rf[RegD], rf[RegE]};
      PairHl:  v = {rf[RegH], rf[RegL]};
      PairSp:  v = sp;
      PairAf:  v = {rf[RegA], rf[RegF]};
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

[sv/lsmu_in_reg.sv]
module lsmu_in_reg
  import lsmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  adv,
  output logic  s1_vld,
  output item_t s1_item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  take;

  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;
  assign vld_nxt  = take || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload only moves on an accepted beat
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_vld  = vld_r;
  assign s1_item = item_r;

endmodule

[sv/lsmu_exec.sv]
module lsmu_exec
  import lsmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  rf_t         rf_r, rf_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  blat_r, blat_nxt;
  logic [15:0] wlat_r, wlat_nxt;
  logic [2:0]  cyc_r, cyc_nxt;
  held_t       held_r, held_nxt;

  held_t       cur;
  logic [2:0]  ph;
  logic        idle_hit;
  logic        done;
  logic [15:0] hl;
  logic [15:0] pv_dst;
  logic [15:0] pv_src;
  logic [7:0]  rd;
  logic        pset_en;
  logic [2:0]  pset_code;
  logic [15:0] pset_val;
  logic [4:0]  h_sum;
  logic [8:0]  c_sum;
  logic [15:0] popv;
  logic [15:0] wlat_hi;

  always_comb begin
    cur.op_kind = item.op_kind;
    cur.dst_sel = item.dst_sel;
    cur.src_sel = item.src_sel;
    cur.step_up = item.step_up;
    if (item.req_type) begin
      cur = held_r;
    end
  end

  assign ph       = item.req_type ? cyc_r : 3'd0;
  assign idle_hit = item.req_type && (cyc_r == 3'd0);
  assign rd       = item.read_data;
  assign hl       = pair_get(rf_r, sp_r, PairHl);
  assign pv_dst   = pair_get(rf_r, sp_r, cur.dst_sel);
  assign pv_src   = pair_get(rf_r, sp_r, cur.src_sel);
  assign h_sum    = {1'b0, sp_r[3:0]} + {1'b0, blat_r[3:0]};
  assign c_sum    = {1'b0, sp_r[7:0]} + {1'b0, blat_r};
  assign wlat_hi  = {rd, wlat_r[7:0]};
  assign popv     = (cur.dst_sel == PairAf) ? ({rd, blat_r} & PopAfMask) : {rd, blat_r};

  always_comb begin
    rf_nxt    = rf_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    blat_nxt  = blat_r;
    wlat_nxt  = wlat_r;
    cyc_nxt   = cyc_r;
    held_nxt  = held_r;
    res       = '0;
    done      = 1'b1;
    pset_en   = 1'b0;
    pset_code = PairHl;
    pset_val  = 16'h0000;

    case (cur.op_kind)
      OP_LD_R_R: begin
        rf_nxt[cur.dst_sel] = rf_r[cur.src_sel];
      end
      OP_LD_R_N: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else begin
          rf_nxt[cur.dst_sel] = rd;
          pc_nxt = pc_r + 16'd1;
        end
      end
      OP_LD_R_HL: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = hl; done = 1'b0;
        end else begin
          rf_nxt[cur.dst_sel] = rd;
        end
      end
      OP_LD_HL_R: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_WR; res.bus_addr = hl;
          res.write_byte = rf_r[cur.src_sel]; done = 1'b0;
        end
      end
      OP_LD_HL_N: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          // immediate byte goes straight out as the M3 write
          blat_nxt = rd;
          pc_nxt = pc_r + 16'd1;
          res.bus_op = BUS_WR; res.bus_addr = hl; res.write_byte = rd; done = 1'b0;
        end
      end
      OP_LD_RR_A: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_WR; res.bus_addr = pv_dst;
          res.write_byte = rf_r[RegA]; done = 1'b0;
        end
      end
      OP_LD_A_RR: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pv_src; done = 1'b0;
        end else begin
          rf_nxt[RegA] = rd;
        end
      end
      OP_LD_NN_A, OP_LD_A_NN: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          wlat_nxt = {8'h00, rd};
          pc_nxt = pc_r + 16'd1;
          res.bus_op = BUS_RD; res.bus_addr = pc_r + 16'd1; done = 1'b0;
        end else if (ph == 3'd2) begin
          wlat_nxt = wlat_hi;
          pc_nxt = pc_r + 16'd1;
          res.bus_addr = wlat_hi;
          if (cur.op_kind == OP_LD_NN_A) begin
            res.bus_op = BUS_WR; res.write_byte = rf_r[RegA];
          end else begin
            res.bus_op = BUS_RD;
          end
          done = 1'b0;
        end else if (cur.op_kind == OP_LD_A_NN) begin
          rf_nxt[RegA] = rd;
        end
      end
      OP_LDH_A_C: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = HiPage | {8'h00, rf_r[RegC]}; done = 1'b0;
        end else begin
          rf_nxt[RegA] = rd;
        end
      end
      OP_LDH_C_A: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_WR; res.bus_addr = HiPage | {8'h00, rf_r[RegC]};
          res.write_byte = rf_r[RegA]; done = 1'b0;
        end
      end
      OP_LDH_A_N, OP_LDH_N_A: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          blat_nxt = rd;
          pc_nxt = pc_r + 16'd1;
          res.bus_addr = HiPage | {8'h00, rd};
          if (cur.op_kind == OP_LDH_A_N) begin
            res.bus_op = BUS_RD;
          end else begin
            res.bus_op = BUS_WR; res.write_byte = rf_r[RegA];
          end
          done = 1'b0;
        end else if (cur.op_kind == OP_LDH_A_N) begin
          rf_nxt[RegA] = rd;
        end
      end
      OP_LD_A_HLI, OP_LD_HLI_A: begin
        if (ph == 3'd0) begin
          res.bus_addr = hl;
          if (cur.op_kind == OP_LD_A_HLI) begin
            res.bus_op = BUS_RD;
          end else begin
            res.bus_op = BUS_WR; res.write_byte = rf_r[RegA];
          end
          done = 1'b0;
        end else begin
          if (cur.op_kind == OP_LD_A_HLI) begin
            rf_nxt[RegA] = rd;
          end
          pset_en = 1'b1; pset_code = PairHl;
          pset_val = cur.step_up ? hl + 16'd1 : hl - 16'd1;
        end
      end
      OP_LD_RR_NN: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          wlat_nxt = {8'h00, rd};
          pc_nxt = pc_r + 16'd1;
          res.bus_op = BUS_RD; res.bus_addr = pc_r + 16'd1; done = 1'b0;
        end else begin
          pc_nxt = pc_r + 16'd1;
          pset_en = 1'b1; pset_code = cur.dst_sel; pset_val = wlat_hi;
        end
      end
      OP_LD_NN_SP: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          wlat_nxt = {8'h00, rd};
          pc_nxt = pc_r + 16'd1;
          res.bus_op = BUS_RD; res.bus_addr = pc_r + 16'd1; done = 1'b0;
        end else if (ph == 3'd2) begin
          wlat_nxt = wlat_hi;
          pc_nxt = pc_r + 16'd1;
          res.bus_op = BUS_WR; res.bus_addr = wlat_hi; res.write_byte = sp_r[7:0];
          done = 1'b0;
        end else if (ph == 3'd3) begin
          res.bus_op = BUS_WR; res.bus_addr = wlat_r + 16'd1;
          res.write_byte = sp_r[15:8]; done = 1'b0;
        end
      end
      OP_LD_SP_HL: begin
        if (ph == 3'd0) begin
          done = 1'b0;
        end else begin
          sp_nxt = hl;
        end
      end
      OP_POP: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = sp_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          blat_nxt = rd;
          sp_nxt = sp_r + 16'd1;
          res.bus_op = BUS_RD; res.bus_addr = sp_r + 16'd1; done = 1'b0;
        end else begin
          // pop into SP lands after the increment and wins
          sp_nxt = sp_r + 16'd1;
          pset_en = 1'b1; pset_code = cur.dst_sel; pset_val = popv;
        end
      end
      OP_PUSH: begin
        if (ph == 3'd0) begin
          done = 1'b0;
        end else if (ph == 3'd1 || ph == 3'd2) begin
          sp_nxt = sp_r - 16'd1;
          res.bus_op = BUS_WR; res.bus_addr = sp_r - 16'd1;
          res.write_byte = (ph == 3'd1) ? pv_dst[15:8] : pv_dst[7:0];
          done = 1'b0;
        end
      end
      OP_LD_HL_SPE: begin
        if (ph == 3'd0) begin
          res.bus_op = BUS_RD; res.bus_addr = pc_r; done = 1'b0;
        end else if (ph == 3'd1) begin
          blat_nxt = rd;
          pc_nxt = pc_r + 16'd1;
          done = 1'b0;
        end else begin
          pset_en = 1'b1; pset_code = PairHl;
          pset_val = sp_r + {{8{blat_r[7]}}, blat_r};
          rf_nxt[RegF] = {2'b00, h_sum[4], c_sum[8], 4'h0};
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (pset_en) begin
      case (pset_code)
        PairBc: begin rf_nxt[RegB] = pset_val[15:8]; rf_nxt[RegC] = pset_val[7:0]; end
        PairDe: begin rf_nxt[RegD] = pset_val[15:8]; rf_nxt[RegE] = pset_val[7:0]; end
        PairHl: begin rf_nxt[RegH] = pset_val[15:8]; rf_nxt[RegL] = pset_val[7:0]; end
        PairSp: sp_nxt = pset_val;
        PairAf: begin rf_nxt[RegA] = pset_val[15:8]; rf_nxt[RegF] = pset_val[7:0]; end
        default: ;
      endcase
    end

    res.done_res = done;
    cyc_nxt  = done ? 3'd0 : ph + 3'd1;
    held_nxt = cur;

    // continue with nothing held: no state change, empty result
    if (idle_hit) begin
      rf_nxt   = rf_r;
      sp_nxt   = sp_r;
      pc_nxt   = pc_r;
      blat_nxt = blat_r;
      wlat_nxt = wlat_r;
      cyc_nxt  = cyc_r;
      held_nxt = held_r;
      res      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r   <= '0;
      sp_r   <= '0;
      pc_r   <= '0;
      blat_r <= '0;
      wlat_r <= '0;
      cyc_r  <= '0;
      held_r <= '0;
    end else if (fire) begin
      rf_r   <= rf_nxt;
      sp_r   <= sp_nxt;
      pc_r   <= pc_nxt;
      blat_r <= blat_nxt;
      wlat_r <= wlat_nxt;
      cyc_r  <= cyc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

[sv/cpu_load_store_mcycle_unit_core.sv]
// channel   ports                                      direction
// input     in_valid, in_stall, in_req_type, in_op_kind, in
//           in_dst_sel, in_src_sel, in_step_up, in_read_data
// result    out_valid, out_stall, out_bus_op, out_bus_addr, out
//           out_write_byte, out_done_res
// one beat per clock sustained while out_stall is low; a result reaches the outputs
// via the input register, then decode/execute into the result register
// the register file, SP, PC and latches update at the edge that loads the result
// rst_n is synchronous and clears all CPU state and both valid flags
// out_stall holds the result register; the input register refills behind it and
// in_stall rises only when both are full
module cpu_load_store_mcycle_unit_core
  import lsmu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [4:0]  in_op_kind,
  input  logic [2:0]  in_dst_sel,
  input  logic [2:0]  in_src_sel,
  input  logic        in_step_up,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_bus_op,
  output logic [15:0] out_bus_addr,
  output logic [7:0]  out_write_byte,
  output logic        out_done_res
);

  item_t in_item;
  item_t s1_item;
  logic  s1_vld;
  logic  adv;
  res_t  res;
  res_t  res_r;
  logic  out_vld_r, out_vld_nxt;

  assign in_item.req_type  = in_req_type;
  assign in_item.op_kind   = in_op_kind;
  assign in_item.dst_sel   = in_dst_sel;
  assign in_item.src_sel   = in_src_sel;
  assign in_item.step_up   = in_step_up;
  assign in_item.read_data = in_read_data;

  // the held beat executes once the result register is free or draining
  assign adv = s1_vld && (!out_vld_r || !out_stall);

  lsmu_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_vld   (s1_vld),
    .s1_item  (s1_item)
  );

  lsmu_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item),
    .res   (res)
  );

  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_bus_op     = res_r.bus_op;
  assign out_bus_addr   = res_r.bus_addr;
  assign out_write_byte = res_r.write_byte;
  assign out_done_res   = res_r.done_res;

endmodule
